@@ rtl/battery_charge_power_supervisor_core_defines.svh @@
// ----------------------------------------------------------------------------
// Battery charge and power supervisor - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_CHARGE_POWER_SUPERVISOR_CORE_DEFINES_SVH
`define BATTERY_CHARGE_POWER_SUPERVISOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define BCPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BCPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bcps_pkg.sv @@
// ----------------------------------------------------------------------------
// Battery charge and power supervisor - package
// Field widths, flag positions, reason and command codes, reset values and
// the item types carried between the channel stages.
// ----------------------------------------------------------------------------
`default_nettype none

package bcps_pkg;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int TEMP_W  = 19;
  localparam int HYST_W  = 15;
  localparam int CNT_W   = 8;
  localparam int FLAGS_W = 12;
  localparam int CF_W    = 3;
  localparam int PF_W    = 2;
  localparam int POLL_W  = 15;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 32;

  // Status flag bit positions
  localparam int FL_DC_PRES  = 0;
  localparam int FL_DC_GOOD  = 1;
  localparam int FL_BAT_PRES = 2;
  localparam int FL_DIS_LO   = 3;
  localparam int FL_DIS_HI   = 4;
  localparam int FL_CHG_LO   = 5;
  localparam int FL_CHG_HI   = 6;
  localparam int FL_CHG_EN   = 7;
  localparam int FL_CHARGING = 8;
  localparam int FL_PWR_ON   = 9;
  localparam int FL_USER_OFF = 10;
  localparam int FL_KEY      = 11;

  // Charge failure reasons
  localparam logic [CF_W-1:0] CF_NONE      = 3'd0;
  localparam logic [CF_W-1:0] CF_LOW_TEMP  = 3'd1;
  localparam logic [CF_W-1:0] CF_HIGH_TEMP = 3'd2;
  localparam logic [CF_W-1:0] CF_NO_DCIN   = 3'd3;
  localparam logic [CF_W-1:0] CF_BAD_DCIN  = 3'd4;
  localparam logic [CF_W-1:0] CF_NO_BAT    = 3'd5;

  // Power failure reasons
  localparam logic [PF_W-1:0] PF_NONE     = 2'd0;
  localparam logic [PF_W-1:0] PF_BAT_LOW  = 2'd1;
  localparam logic [PF_W-1:0] PF_TEMP_LOW = 2'd2;
  localparam logic [PF_W-1:0] PF_TEMP_HI  = 2'd3;

  // Item kinds
  localparam logic [1:0] FN_TICK = 2'd0;
  localparam logic [1:0] FN_KEY  = 2'd1;
  localparam logic [1:0] FN_CMD  = 2'd2;

  // Key events
  localparam logic [1:0] KEY_PRESS        = 2'd0;
  localparam logic [1:0] KEY_RELEASE      = 2'd1;
  localparam logic [1:0] KEY_LONG_PRESS   = 2'd2;
  localparam logic [1:0] KEY_LONG_RELEASE = 2'd3;

  // Power commands
  localparam logic [1:0] CMD_ON       = 2'd0;
  localparam logic [1:0] CMD_SHUTDOWN = 2'd1;
  localparam logic [1:0] CMD_REBOOT   = 2'd2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_TEMP_MIN_DIS = 3'd0;
  localparam logic [IDX_W-1:0] REG_TEMP_MAX_DIS = 3'd1;
  localparam logic [IDX_W-1:0] REG_TEMP_MIN_CHG = 3'd2;
  localparam logic [IDX_W-1:0] REG_TEMP_MAX_CHG = 3'd3;
  localparam logic [IDX_W-1:0] REG_TEMP_HYST    = 3'd4;
  localparam logic [IDX_W-1:0] REG_RETRY_TEMP   = 3'd5;
  localparam logic [IDX_W-1:0] REG_RETRY_LOST   = 3'd6;
  localparam logic [IDX_W-1:0] REG_RETRY_BAD    = 3'd7;

  // Register reset values
  localparam logic signed [TEMP_W-1:0] RST_TEMP_MIN_DIS = -19'sd20000;
  localparam logic signed [TEMP_W-1:0] RST_TEMP_MAX_DIS = 19'sd60000;
  localparam logic signed [TEMP_W-1:0] RST_TEMP_MIN_CHG = 19'sd0;
  localparam logic signed [TEMP_W-1:0] RST_TEMP_MAX_CHG = 19'sd45000;
  localparam logic [HYST_W-1:0]        RST_TEMP_HYST    = 15'd2000;
  localparam logic [TIME_W-1:0]        RST_RETRY_TEMP   = 32'd60000;
  localparam logic [TIME_W-1:0]        RST_RETRY_LOST   = 32'd5000;
  localparam logic [TIME_W-1:0]        RST_RETRY_BAD    = 32'd600000;

  // Fixed timing and limits
  localparam logic [TIME_W-1:0] MIN_CHARGE_MS  = 32'd10000;
  localparam logic [CNT_W-1:0]  BAD_DCIN_LIMIT = 8'd5;
  localparam logic [TIME_W-1:0] DCIN_SETTLE_MS = 32'd5000;
  localparam logic [CNT_W-1:0]  CNT_MAX        = 8'd255;

  // Poll intervals
  localparam logic [POLL_W-1:0] POLL_CHARGING = 15'd200;
  localparam logic [POLL_W-1:0] POLL_CHG_EN   = 15'd500;
  localparam logic [POLL_W-1:0] POLL_DCIN     = 15'd1000;
  localparam logic [POLL_W-1:0] POLL_IDLE     = 15'd30000;
  localparam logic [POLL_W-1:0] POLL_REBOOT   = 15'd2000;

  // One input item
  typedef struct packed {
    logic [1:0]               func;
    logic [TIME_W-1:0]        now_ms;
    logic                     dc_detect;
    logic                     dc_in_range;
    logic                     bat_detect;
    logic signed [TEMP_W-1:0] bat_temp;
    logic                     bat_discharged;
    logic                     charger_active;
    logic [1:0]               key_event;
    logic [1:0]               power_cmd;
    logic                     dcin_pin_level;
    logic                     key_pin_level;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [FLAGS_W-1:0] status_flags;
    logic               charger_enable;
    logic               supply_enable;
    logic               irq_raise;
    logic [CF_W-1:0]    charge_fail_reason;
    logic [PF_W-1:0]    power_fail_reason;
    logic               ignore_dcin_voltage;
    logic [POLL_W-1:0]  next_poll_ms;
    logic               sleep_allowed;
  } res_item_t;

endpackage

`default_nettype wire

@@ rtl/bcps_if.sv @@
// ----------------------------------------------------------------------------
// Battery charge and power supervisor - channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

// Input item channel
interface bcps_in_if
  import bcps_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [1:0]               func;
  logic [TIME_W-1:0]        now_ms;
  logic                     dc_detect;
  logic                     dc_in_range;
  logic                     bat_detect;
  logic signed [TEMP_W-1:0] bat_temp;
  logic                     bat_discharged;
  logic                     charger_active;
  logic [1:0]               key_event;
  logic [1:0]               power_cmd;
  logic                     dcin_pin_level;
  logic                     key_pin_level;

  modport source (
    output valid, func, now_ms, dc_detect, dc_in_range, bat_detect, bat_temp,
           bat_discharged, charger_active, key_event, power_cmd, dcin_pin_level,
           key_pin_level,
    input  ready
  );
  modport sink (
    input  valid, func, now_ms, dc_detect, dc_in_range, bat_detect, bat_temp,
           bat_discharged, charger_active, key_event, power_cmd, dcin_pin_level,
           key_pin_level,
    output ready
  );
endinterface

// Result item channel
interface bcps_out_if
  import bcps_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FLAGS_W-1:0] status_flags;
  logic               charger_enable;
  logic               supply_enable;
  logic               irq_raise;
  logic [CF_W-1:0]    charge_fail_reason;
  logic [PF_W-1:0]    power_fail_reason;
  logic               ignore_dcin_voltage;
  logic [POLL_W-1:0]  next_poll_ms;
  logic               sleep_allowed;

  modport source (
    output valid, status_flags, charger_enable, supply_enable, irq_raise,
           charge_fail_reason, power_fail_reason, ignore_dcin_voltage,
           next_poll_ms, sleep_allowed,
    input  ready
  );
  modport sink (
    input  valid, status_flags, charger_enable, supply_enable, irq_raise,
           charge_fail_reason, power_fail_reason, ignore_dcin_voltage,
           next_poll_ms, sleep_allowed,
    output ready
  );
endinterface

// Register write channel
interface bcps_cfg_if
  import bcps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/battery_charge_power_supervisor_core.sv @@
// ----------------------------------------------------------------------------
// Battery charge and power supervisor core
// Keeps the PMIC status flags, temperature limits, charge hold-off and power
// state; turns each tick, key event or power command into one status result.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one transfer per monitor tick, power key event or power command.
//   out_ch : one result per input item, in the same order.
//   cfg    : register writes, always ready; write only while the core is idle.
// Path: an accepted item is registered in the input stage and is then
//   evaluated into the result register.
// Throughput: one item per cycle while results are taken. The whole update
//   (temperature compares with hysteresis, charge check, hold-off compare,
//   power check, poll choice) is one pass of logic between the input stage
//   and the result register.
// Reset: flags, counters, timestamps and the ignore-DCIN request clear to
//   zero, registers take their default limits and both stages empty.
// Stall: a result held by the receiver keeps its register; the input stage
//   still takes one more item and then input ready drops until the result
//   is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "battery_charge_power_supervisor_core_defines.svh"

module battery_charge_power_supervisor_core
  import bcps_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  bcps_in_if.sink     in_ch,
  bcps_out_if.source  out_ch,
  bcps_cfg_if.sink    cfg
);

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [CF_W-1:0] charge_check(
    input logic             bat_pres,
    input logic             dc_pres,
    input logic             dc_good,
    input logic [CNT_W-1:0] bad_cnt,
    input logic             chg_lo,
    input logic             chg_hi
  );
    logic [CF_W-1:0] r;
    if (!bat_pres) begin
      r = CF_NO_BAT;
    end else if (!dc_pres) begin
      r = CF_NO_DCIN;
    end else if (!dc_good) begin
      r = (bad_cnt >= BAD_DCIN_LIMIT) ? CF_BAD_DCIN : CF_NO_DCIN;
    end else if (chg_lo) begin
      r = CF_LOW_TEMP;
    end else if (chg_hi) begin
      r = CF_HIGH_TEMP;
    end else begin
      r = CF_NONE;
    end
    return r;
  endfunction

  function automatic logic [PF_W-1:0] power_check(
    input logic dc_good,
    input logic discharged,
    input logic dis_lo,
    input logic dis_hi
  );
    logic [PF_W-1:0] r;
    r = PF_NONE;
    if (!dc_good) begin
      if (discharged) begin
        r = PF_BAT_LOW;
      end else if (dis_lo) begin
        r = PF_TEMP_LOW;
      end else if (dis_hi) begin
        r = PF_TEMP_HI;
      end
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c != CNT_MAX) ? c + 1'b1 : c;
  endfunction

  // --------------------------------------------------------------------------
  // Registers and state
  // --------------------------------------------------------------------------
  logic signed [TEMP_W-1:0] reg_tmin_dis, reg_tmax_dis, reg_tmin_chg, reg_tmax_chg;
  logic [HYST_W-1:0]        reg_hyst;
  logic [TIME_W-1:0]        reg_retry_temp, reg_retry_lost, reg_retry_bad;

  logic [FLAGS_W-1:0] flags, flags_next;
  logic [CF_W-1:0]    last_fail_reason, last_fail_reason_next;
  logic [TIME_W-1:0]  last_fail_time, last_fail_time_next;
  logic [CNT_W-1:0]   fail_count, fail_count_next;
  logic [CNT_W-1:0]   bad_dcin_count, bad_dcin_count_next;
  logic [TIME_W-1:0]  charge_start_time, charge_start_time_next;
  logic [TIME_W-1:0]  dcin_connect_time, dcin_connect_time_next;
  logic               ignore_dcin, ignore_dcin_next;

  // Pipeline stages
  in_item_t  s1;
  logic      s1_valid;
  res_item_t res, res_next;
  logic      res_valid;
  logic      advance;

  // Evaluation signals
  logic signed [TEMP_W:0] t_ext;
  logic signed [TEMP_W:0] dis_lo_ext, dis_hi_ext, chg_lo_ext, chg_hi_ext;
  logic signed [TEMP_W:0] dis_lo_rec, dis_hi_rec, chg_lo_rec, chg_hi_rec;
  logic                   dis_lo_new, dis_hi_new, chg_lo_new, chg_hi_new;
  logic [TIME_W-1:0]      holdoff, since_fail, since_start, since_connect;
  logic                   dc_rising, disabled;
  logic [CF_W-1:0]        cfail;
  logic [PF_W-1:0]        pfail_tick;
  logic [POLL_W-1:0]      poll;
  logic                   sleep;

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign advance     = s1_valid && (!res_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;
  assign cfg.ready   = 1'b1;

  // Capture input transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1.func           <= in_ch.func;
      s1.now_ms         <= in_ch.now_ms;
      s1.dc_detect      <= in_ch.dc_detect;
      s1.dc_in_range    <= in_ch.dc_in_range;
      s1.bat_detect     <= in_ch.bat_detect;
      s1.bat_temp       <= in_ch.bat_temp;
      s1.bat_discharged <= in_ch.bat_discharged;
      s1.charger_active <= in_ch.charger_active;
      s1.key_event      <= in_ch.key_event;
      s1.power_cmd      <= in_ch.power_cmd;
      s1.dcin_pin_level <= in_ch.dcin_pin_level;
      s1.key_pin_level  <= in_ch.key_pin_level;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_tmin_dis   <= RST_TEMP_MIN_DIS;
      reg_tmax_dis   <= RST_TEMP_MAX_DIS;
      reg_tmin_chg   <= RST_TEMP_MIN_CHG;
      reg_tmax_chg   <= RST_TEMP_MAX_CHG;
      reg_hyst       <= RST_TEMP_HYST;
      reg_retry_temp <= RST_RETRY_TEMP;
      reg_retry_lost <= RST_RETRY_LOST;
      reg_retry_bad  <= RST_RETRY_BAD;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_TEMP_MIN_DIS: reg_tmin_dis   <= cfg.data[TEMP_W-1:0];
        REG_TEMP_MAX_DIS: reg_tmax_dis   <= cfg.data[TEMP_W-1:0];
        REG_TEMP_MIN_CHG: reg_tmin_chg   <= cfg.data[TEMP_W-1:0];
        REG_TEMP_MAX_CHG: reg_tmax_chg   <= cfg.data[TEMP_W-1:0];
        REG_TEMP_HYST:    reg_hyst       <= cfg.data[HYST_W-1:0];
        REG_RETRY_TEMP:   reg_retry_temp <= cfg.data;
        REG_RETRY_LOST:   reg_retry_lost <= cfg.data;
        REG_RETRY_BAD:    reg_retry_bad  <= cfg.data;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Temperature limits with hysteresis
  // --------------------------------------------------------------------------
  assign t_ext      = {s1.bat_temp[TEMP_W-1], s1.bat_temp};
  assign dis_lo_ext = {reg_tmin_dis[TEMP_W-1], reg_tmin_dis};
  assign dis_hi_ext = {reg_tmax_dis[TEMP_W-1], reg_tmax_dis};
  assign chg_lo_ext = {reg_tmin_chg[TEMP_W-1], reg_tmin_chg};
  assign chg_hi_ext = {reg_tmax_chg[TEMP_W-1], reg_tmax_chg};

  // Recovery points: low limits clear above limit plus margin, high below
  assign dis_lo_rec = dis_lo_ext + $signed({{(TEMP_W + 1 - HYST_W){1'b0}}, reg_hyst});
  assign dis_hi_rec = dis_hi_ext - $signed({{(TEMP_W + 1 - HYST_W){1'b0}}, reg_hyst});
  assign chg_lo_rec = chg_lo_ext + $signed({{(TEMP_W + 1 - HYST_W){1'b0}}, reg_hyst});
  assign chg_hi_rec = chg_hi_ext - $signed({{(TEMP_W + 1 - HYST_W){1'b0}}, reg_hyst});

  // Keep a flag until recovered, set it at its limit
  assign dis_lo_new = (flags[FL_DIS_LO] && !(t_ext > dis_lo_rec)) || (t_ext <= dis_lo_ext);
  assign dis_hi_new = (flags[FL_DIS_HI] && !(t_ext < dis_hi_rec)) || (t_ext >= dis_hi_ext);
  assign chg_lo_new = (flags[FL_CHG_LO] && !(t_ext > chg_lo_rec)) || (t_ext <= chg_lo_ext);
  assign chg_hi_new = (flags[FL_CHG_HI] && !(t_ext < chg_hi_rec)) || (t_ext >= chg_hi_ext);

  assign dc_rising = !flags[FL_DC_PRES] && s1.dc_detect;

  // --------------------------------------------------------------------------
  // Item evaluation
  // --------------------------------------------------------------------------
  always_comb begin
    flags_next             = flags;
    last_fail_reason_next  = last_fail_reason;
    last_fail_time_next    = last_fail_time;
    fail_count_next        = fail_count;
    bad_dcin_count_next    = bad_dcin_count;
    charge_start_time_next = charge_start_time;
    dcin_connect_time_next = dcin_connect_time;
    ignore_dcin_next       = ignore_dcin;
    cfail                  = CF_NONE;
    pfail_tick             = PF_NONE;
    poll                   = '0;
    sleep                  = 1'b0;
    holdoff                = '0;
    since_fail             = '0;
    since_start            = '0;
    since_connect          = '0;
    disabled               = 1'b0;

    unique case (s1.func)
      FN_TICK: begin
        // Supply presence; a reconnect downgrades a bad-supply failure
        flags_next[FL_DC_PRES] = s1.dc_detect;
        if (dc_rising) begin
          dcin_connect_time_next = s1.now_ms;
          if (last_fail_reason == CF_BAD_DCIN) begin
            last_fail_reason_next = CF_NO_DCIN;
            fail_count_next       = '0;
            last_fail_time_next   = s1.now_ms;
            bad_dcin_count_next   = '0;
          end
        end
        flags_next[FL_DC_GOOD]  = s1.dc_detect && s1.dc_in_range;
        flags_next[FL_BAT_PRES] = s1.bat_detect;
        flags_next[FL_DIS_LO]   = dis_lo_new;
        flags_next[FL_DIS_HI]   = dis_hi_new;
        flags_next[FL_CHG_LO]   = chg_lo_new;
        flags_next[FL_CHG_HI]   = chg_hi_new;

        cfail = charge_check(flags_next[FL_BAT_PRES], flags_next[FL_DC_PRES],
                             flags_next[FL_DC_GOOD], bad_dcin_count_next,
                             chg_lo_new, chg_hi_new);

        // Hold-off after the last failure
        case (last_fail_reason_next) inside
          CF_LOW_TEMP, CF_HIGH_TEMP: holdoff = reg_retry_temp;
          CF_NO_DCIN:                holdoff = reg_retry_lost;
          CF_BAD_DCIN:               holdoff = reg_retry_bad;
          default:                   holdoff = '0;
        endcase
        since_fail = s1.now_ms - last_fail_time_next;
        disabled   = !flags_next[FL_DC_GOOD] ||
                     ((last_fail_time_next != '0) && (since_fail < holdoff));

        // Start charging
        if (!flags_next[FL_CHG_EN] && (cfail == CF_NONE) && !disabled) begin
          charge_start_time_next = s1.now_ms;
          flags_next[FL_CHG_EN]  = 1'b1;
        end

        // Drop charging on a failure; count short charge runs
        since_start = s1.now_ms - charge_start_time_next;
        if (flags_next[FL_CHG_EN] && (cfail != CF_NONE)) begin
          last_fail_reason_next = cfail;
          last_fail_time_next   = s1.now_ms;
          if (since_start < MIN_CHARGE_MS) begin
            fail_count_next = sat_inc(fail_count_next);
            if (cfail == CF_NO_DCIN) begin
              bad_dcin_count_next = sat_inc(bad_dcin_count_next);
            end
          end else begin
            fail_count_next     = '0;
            bad_dcin_count_next = '0;
          end
          flags_next[FL_CHG_EN] = 1'b0;
        end
        flags_next[FL_CHARGING] = s1.charger_active && flags_next[FL_CHG_EN];

        // Automatic power on, forced power off
        pfail_tick = power_check(flags_next[FL_DC_GOOD], s1.bat_discharged,
                                 dis_lo_new, dis_hi_new);
        if (pfail_tick == PF_NONE) begin
          if (!flags[FL_PWR_ON] && !flags[FL_USER_OFF]) begin
            flags_next[FL_PWR_ON] = 1'b1;
          end
        end else if (flags[FL_PWR_ON]) begin
          flags_next[FL_PWR_ON]   = 1'b0;
          flags_next[FL_USER_OFF] = 1'b0;
        end

        // Choose the poll interval or grant sleep
        since_connect = s1.now_ms - dcin_connect_time_next;
        if (flags_next[FL_CHARGING]) begin
          poll = POLL_CHARGING;
        end else if (flags_next[FL_CHG_EN]) begin
          poll = POLL_CHG_EN;
        end else if (flags_next[FL_DC_GOOD]) begin
          poll = POLL_DCIN;
        end else if (flags_next[FL_DC_PRES] && (since_connect <= DCIN_SETTLE_MS)) begin
          poll = POLL_DCIN;
        end else if (!flags_next[FL_PWR_ON] && !flags_next[FL_DC_PRES] &&
                     !s1.dcin_pin_level && !s1.key_pin_level) begin
          sleep = 1'b1;
        end else begin
          poll = POLL_IDLE;
        end
      end

      FN_KEY: begin
        case (s1.key_event)
          KEY_PRESS: begin
            ignore_dcin_next = 1'b1;
          end
          KEY_RELEASE: begin
            ignore_dcin_next        = 1'b0;
            flags_next[FL_USER_OFF] = 1'b0;
          end
          KEY_LONG_PRESS: begin
            flags_next[FL_PWR_ON]   = 1'b0;
            flags_next[FL_USER_OFF] = 1'b1;
          end
          default: begin
            ignore_dcin_next = 1'b0;
          end
        endcase
        flags_next[FL_KEY] = (s1.key_event == KEY_PRESS) ||
                             (s1.key_event == KEY_LONG_PRESS);
        cfail = charge_check(flags[FL_BAT_PRES], flags[FL_DC_PRES], flags[FL_DC_GOOD],
                             bad_dcin_count, flags[FL_CHG_LO], flags[FL_CHG_HI]);
      end

      FN_CMD: begin
        case (s1.power_cmd)
          CMD_ON: begin
            if (power_check(flags[FL_DC_GOOD], s1.bat_discharged, flags[FL_DIS_LO],
                            flags[FL_DIS_HI]) == PF_NONE) begin
              flags_next[FL_PWR_ON]   = 1'b1;
              flags_next[FL_USER_OFF] = 1'b0;
            end
          end
          CMD_SHUTDOWN: begin
            flags_next[FL_PWR_ON]   = 1'b0;
            flags_next[FL_USER_OFF] = 1'b1;
          end
          CMD_REBOOT: begin
            flags_next[FL_PWR_ON]   = 1'b0;
            flags_next[FL_USER_OFF] = 1'b0;
            poll                    = POLL_REBOOT;
          end
          default: begin
          end
        endcase
        cfail = charge_check(flags[FL_BAT_PRES], flags[FL_DC_PRES], flags[FL_DC_GOOD],
                             bad_dcin_count, flags[FL_CHG_LO], flags[FL_CHG_HI]);
      end

      default: begin
        cfail = charge_check(flags[FL_BAT_PRES], flags[FL_DC_PRES], flags[FL_DC_GOOD],
                             bad_dcin_count, flags[FL_CHG_LO], flags[FL_CHG_HI]);
      end
    endcase
  end

  // Assemble the result
  always_comb begin
    res_next.status_flags        = flags_next;
    res_next.charger_enable      = flags_next[FL_CHG_EN];
    res_next.supply_enable       = flags_next[FL_PWR_ON];
    res_next.irq_raise           = (flags_next != flags);
    res_next.charge_fail_reason  = cfail;
    res_next.power_fail_reason   = power_check(flags_next[FL_DC_GOOD], s1.bat_discharged,
                                               flags_next[FL_DIS_LO],
                                               flags_next[FL_DIS_HI]);
    res_next.ignore_dcin_voltage = ignore_dcin_next;
    res_next.next_poll_ms        = poll;
    res_next.sleep_allowed       = sleep;
  end

  // --------------------------------------------------------------------------
  // State and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      flags             <= '0;
      last_fail_reason  <= CF_NONE;
      last_fail_time    <= '0;
      fail_count        <= '0;
      bad_dcin_count    <= '0;
      charge_start_time <= '0;
      dcin_connect_time <= '0;
      ignore_dcin       <= 1'b0;
    end else if (advance) begin
      flags             <= flags_next;
      last_fail_reason  <= last_fail_reason_next;
      last_fail_time    <= last_fail_time_next;
      fail_count        <= fail_count_next;
      bad_dcin_count    <= bad_dcin_count_next;
      charge_start_time <= charge_start_time_next;
      dcin_connect_time <= dcin_connect_time_next;
      ignore_dcin       <= ignore_dcin_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  // Drive the result channel
  assign out_ch.valid               = res_valid;
  assign out_ch.status_flags        = res.status_flags;
  assign out_ch.charger_enable      = res.charger_enable;
  assign out_ch.supply_enable       = res.supply_enable;
  assign out_ch.irq_raise           = res.irq_raise;
  assign out_ch.charge_fail_reason  = res.charge_fail_reason;
  assign out_ch.power_fail_reason   = res.power_fail_reason;
  assign out_ch.ignore_dcin_voltage = res.ignore_dcin_voltage;
  assign out_ch.next_poll_ms        = res.next_poll_ms;
  assign out_ch.sleep_allowed       = res.sleep_allowed;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `BCPS_ASSERT_NEXT(a_adv_fills_result, advance, res_valid,
    "evaluated item did not reach the result register")
  `BCPS_ASSERT_NEXT(a_stage_holds, s1_valid && !advance, s1_valid,
    "input stage lost an item that was not evaluated")
  `BCPS_ASSERT_NOW(a_pin_drives, res_valid,
    (res.charger_enable == res.status_flags[FL_CHG_EN]) &&
    (res.supply_enable == res.status_flags[FL_PWR_ON]),
    "pin drives disagree with status flags")
  `BCPS_ASSERT_NOW(a_sleep_quiet, res_valid && res.sleep_allowed,
    (res.next_poll_ms == '0) && !res.status_flags[FL_PWR_ON] &&
    !res.status_flags[FL_DC_PRES],
    "sleep granted with polling or supply active")

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// Battery charge and power supervisor - testbench
// Drives monitor ticks, key events and power commands into the core and
// predicts every status result in a scoreboard. Results are checked field by
// field, in order. Register settings change between phases while the core is
// drained. Both channels idle at random, and the result side is held off once
// for long enough to back the core up onto its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import bcps_pkg::*;

  // Codes with no name in the package
  localparam logic [1:0] FN_NONE     = 2'd3;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  // Scoreboard: shadow of the supervisor state and the expected status queue
  class status_predictor;
    logic signed [TEMP_W-1:0] lim [4];
    logic [HYST_W-1:0]        hyst;
    logic [TIME_W-1:0]        retry [3];
    logic [FLAGS_W-1:0]       flags;
    logic [CF_W-1:0]          fail_reason;
    logic [TIME_W-1:0]        fail_time;
    logic [TIME_W-1:0]        chg_start;
    logic [TIME_W-1:0]        dc_connect;
    logic [CNT_W-1:0]         fail_cnt;
    logic [CNT_W-1:0]         bad_cnt;
    logic                     ign;
    res_item_t                expected_status [$];
    int                       mismatches;

    function new();
      lim[0]      = RST_TEMP_MIN_DIS;
      lim[1]      = RST_TEMP_MAX_DIS;
      lim[2]      = RST_TEMP_MIN_CHG;
      lim[3]      = RST_TEMP_MAX_CHG;
      hyst        = RST_TEMP_HYST;
      retry[0]    = RST_RETRY_TEMP;
      retry[1]    = RST_RETRY_LOST;
      retry[2]    = RST_RETRY_BAD;
      flags       = '0;
      fail_reason = CF_NONE;
      fail_time   = '0;
      chg_start   = '0;
      dc_connect  = '0;
      fail_cnt    = '0;
      bad_cnt     = '0;
      ign         = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx) inside
        REG_TEMP_MIN_DIS, REG_TEMP_MAX_DIS, REG_TEMP_MIN_CHG, REG_TEMP_MAX_CHG: begin
          lim[idx] = data[TEMP_W-1:0];
        end
        REG_TEMP_HYST: begin
          hyst = data[HYST_W-1:0];
        end
        default: begin
          retry[idx - REG_RETRY_TEMP] = data;
        end
      endcase
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
      return (c < CNT_MAX) ? c + 1'b1 : CNT_MAX;
    endfunction

    // Limit flags set at the limit and clear only past the hysteresis margin
    function void track_limits(longint t, logic signed [TEMP_W-1:0] lo,
                               logic signed [TEMP_W-1:0] hi, int flo, int fhi);
      longint h;
      longint l;
      longint u;
      h = hyst;
      l = lo;
      u = hi;
      if (flags[flo] && t > l + h) flags[flo] = 1'b0;
      if (flags[fhi] && t < u - h) flags[fhi] = 1'b0;
      if (!flags[flo] && t <= l) flags[flo] = 1'b1;
      if (!flags[fhi] && t >= u) flags[fhi] = 1'b1;
    endfunction

    function logic [CF_W-1:0] charge_reason();
      if (!flags[FL_BAT_PRES]) return CF_NO_BAT;
      if (!flags[FL_DC_PRES]) return CF_NO_DCIN;
      if (!flags[FL_DC_GOOD]) return (bad_cnt >= BAD_DCIN_LIMIT) ? CF_BAD_DCIN : CF_NO_DCIN;
      if (flags[FL_CHG_LO]) return CF_LOW_TEMP;
      if (flags[FL_CHG_HI]) return CF_HIGH_TEMP;
      return CF_NONE;
    endfunction

    function logic [PF_W-1:0] power_reason(logic disc);
      if (!flags[FL_DC_GOOD]) begin
        if (disc) return PF_BAT_LOW;
        if (flags[FL_DIS_LO]) return PF_TEMP_LOW;
        if (flags[FL_DIS_HI]) return PF_TEMP_HI;
      end
      return PF_NONE;
    endfunction

    function void power_up(logic disc);
      if (power_reason(disc) == PF_NONE) begin
        flags[FL_PWR_ON]   = 1'b1;
        flags[FL_USER_OFF] = 1'b0;
      end
    endfunction

    function void power_down(logic user);
      flags[FL_PWR_ON]   = 1'b0;
      flags[FL_USER_OFF] = user;
    endfunction

    // Advance the shadow state by one accepted item and queue its status
    function void take_item(in_item_t it);
      logic [FLAGS_W-1:0] prior;
      logic [CF_W-1:0]    cf;
      logic [POLL_W-1:0]  poll;
      logic               slp;
      logic               was_pres;
      logic               blocked;
      logic [TIME_W-1:0]  hold;
      longint             t;
      res_item_t          e;
      prior = flags;
      poll  = '0;
      slp   = 1'b0;
      if (it.func == FN_TICK) begin
        was_pres = flags[FL_DC_PRES];
        flags[FL_DC_PRES] = it.dc_detect;
        if (!was_pres && it.dc_detect) begin
          dc_connect = it.now_ms;
          // Reconnecting clears a bad-supply lockout
          if (fail_reason == CF_BAD_DCIN) begin
            fail_reason = CF_NO_DCIN;
            fail_cnt    = '0;
            fail_time   = it.now_ms;
            bad_cnt     = '0;
          end
        end
        flags[FL_DC_GOOD]  = it.dc_detect && it.dc_in_range;
        flags[FL_BAT_PRES] = it.bat_detect;
        t = longint'(signed'(it.bat_temp));
        track_limits(t, lim[0], lim[1], FL_DIS_LO, FL_DIS_HI);
        track_limits(t, lim[2], lim[3], FL_CHG_LO, FL_CHG_HI);
        cf = charge_reason();
        case (fail_reason) inside
          CF_LOW_TEMP, CF_HIGH_TEMP: hold = retry[0];
          CF_NO_DCIN:                hold = retry[1];
          CF_BAD_DCIN:               hold = retry[2];
          default:                   hold = '0;
        endcase
        // A failure time of zero reads as never failed
        blocked = !flags[FL_DC_GOOD] ||
                  (fail_time != '0 && TIME_W'(it.now_ms - fail_time) < hold);
        if (!flags[FL_CHG_EN] && cf == CF_NONE && !blocked) begin
          chg_start = it.now_ms;
          flags[FL_CHG_EN] = 1'b1;
        end
        if (flags[FL_CHG_EN] && cf != CF_NONE) begin
          fail_reason = cf;
          fail_time   = it.now_ms;
          if (TIME_W'(it.now_ms - chg_start) < MIN_CHARGE_MS) begin
            fail_cnt = bump(fail_cnt);
            if (cf == CF_NO_DCIN) bad_cnt = bump(bad_cnt);
          end else begin
            fail_cnt = '0;
            bad_cnt  = '0;
          end
          flags[FL_CHG_EN] = 1'b0;
        end
        flags[FL_CHARGING] = it.charger_active && flags[FL_CHG_EN];
        if (!flags[FL_PWR_ON] && !flags[FL_USER_OFF]) power_up(it.bat_discharged);
        if (flags[FL_PWR_ON] && power_reason(it.bat_discharged) != PF_NONE) power_down(1'b0);
        // Pick the next poll delay, or grant sleep
        if (flags[FL_CHARGING]) begin
          poll = POLL_CHARGING;
        end else if (flags[FL_CHG_EN]) begin
          poll = POLL_CHG_EN;
        end else if (flags[FL_DC_GOOD]) begin
          poll = POLL_DCIN;
        end else if (flags[FL_DC_PRES] &&
                     TIME_W'(it.now_ms - dc_connect) <= DCIN_SETTLE_MS) begin
          poll = POLL_DCIN;
        end else if (!flags[FL_PWR_ON] && !flags[FL_DC_PRES] &&
                     !it.dcin_pin_level && !it.key_pin_level) begin
          slp = 1'b1;
        end else begin
          poll = POLL_IDLE;
        end
      end else begin
        if (it.func == FN_KEY) begin
          case (it.key_event)
            KEY_PRESS: begin
              ign = 1'b1;
            end
            KEY_RELEASE: begin
              ign = 1'b0;
              flags[FL_USER_OFF] = 1'b0;
            end
            KEY_LONG_PRESS: begin
              power_down(1'b1);
            end
            default: begin
              ign = 1'b0;
            end
          endcase
          flags[FL_KEY] = (it.key_event == KEY_PRESS) || (it.key_event == KEY_LONG_PRESS);
        end else if (it.func == FN_CMD) begin
          case (it.power_cmd)
            CMD_ON:       power_up(it.bat_discharged);
            CMD_SHUTDOWN: power_down(1'b1);
            CMD_REBOOT: begin
              power_down(1'b0);
              poll = POLL_REBOOT;
            end
            default: ;
          endcase
        end
        cf = charge_reason();
      end
      e.status_flags        = flags;
      e.charger_enable      = flags[FL_CHG_EN];
      e.supply_enable       = flags[FL_PWR_ON];
      e.irq_raise           = (flags != prior);
      e.charge_fail_reason  = cf;
      e.power_fail_reason   = power_reason(it.bat_discharged);
      e.ignore_dcin_voltage = ign;
      e.next_poll_ms        = poll;
      e.sleep_allowed       = slp;
      expected_status.push_back(e);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch in %s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    // Match one transferred result against the oldest expected status
    function void check_status(res_item_t got);
      res_item_t want;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result, status flags %0h", got.status_flags);
        return;
      end
      want = expected_status.pop_front();
      compare("status_flags", want.status_flags, got.status_flags);
      compare("charger_enable", want.charger_enable, got.charger_enable);
      compare("supply_enable", want.supply_enable, got.supply_enable);
      compare("irq_raise", want.irq_raise, got.irq_raise);
      compare("charge_fail_reason", want.charge_fail_reason, got.charge_fail_reason);
      compare("power_fail_reason", want.power_fail_reason, got.power_fail_reason);
      compare("ignore_dcin_voltage", want.ignore_dcin_voltage, got.ignore_dcin_voltage);
      compare("next_poll_ms", want.next_poll_ms, got.next_poll_ms);
      compare("sleep_allowed", want.sleep_allowed, got.sleep_allowed);
    endfunction
  endclass

  logic clk;
  logic rst;

  bcps_in_if  in_bus ();
  bcps_out_if out_bus ();
  bcps_cfg_if cfg_bus ();

  battery_charge_power_supervisor_core DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg    (cfg_bus)
  );

  status_predictor model = new();

  // Stimulus world: time and measurements that evolve from item to item
  logic              steady;
  logic [TIME_W-1:0] w_time;
  logic              w_dc;
  logic              w_good;
  logic              w_bat;
  int                w_temp;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Offer one item, with random idle cycles ahead of it, until transferred
  task automatic send_item(in_item_t it);
    logic got;
    while (!steady && $urandom_range(99) < 24) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.func           <= it.func;
    in_bus.now_ms         <= it.now_ms;
    in_bus.dc_detect      <= it.dc_detect;
    in_bus.dc_in_range    <= it.dc_in_range;
    in_bus.bat_detect     <= it.bat_detect;
    in_bus.bat_temp       <= it.bat_temp;
    in_bus.bat_discharged <= it.bat_discharged;
    in_bus.charger_active <= it.charger_active;
    in_bus.key_event      <= it.key_event;
    in_bus.power_cmd      <= it.power_cmd;
    in_bus.dcin_pin_level <= it.dcin_pin_level;
    in_bus.key_pin_level  <= it.key_pin_level;
    do begin
      @(negedge clk);
      got = in_bus.ready;
      @(posedge clk);
    end while (!got);
    model.take_item(it);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] d);
    logic got;
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    do begin
      @(negedge clk);
      got = cfg_bus.ready;
      @(posedge clk);
    end while (!got);
    model.set_reg(idx, d);
  endtask

  task automatic program_regs(int mind, int maxd, int minc, int maxc, int hy,
                              logic [31:0] r_temp, logic [31:0] r_lost,
                              logic [31:0] r_bad);
    write_reg(REG_TEMP_MIN_DIS, mind);
    write_reg(REG_TEMP_MAX_DIS, maxd);
    write_reg(REG_TEMP_MIN_CHG, minc);
    write_reg(REG_TEMP_MAX_CHG, maxc);
    write_reg(REG_TEMP_HYST, hy);
    write_reg(REG_RETRY_TEMP, r_temp);
    write_reg(REG_RETRY_LOST, r_lost);
    write_reg(REG_RETRY_BAD, r_bad);
    cfg_bus.valid <= 1'b0;
  endtask

  // Drop valid and hold until every expected status has come back
  task automatic drain(int settle);
    in_bus.valid <= 1'b0;
    while (model.expected_status.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic in_item_t tick_item(logic [TIME_W-1:0] now, logic dc, logic good,
                                         logic bat, int temp, logic disc, logic chg,
                                         logic [1:0] pins);
    in_item_t it;
    it                = '0;
    it.func           = FN_TICK;
    it.now_ms         = now;
    it.dc_detect      = dc;
    it.dc_in_range    = good;
    it.bat_detect     = bat;
    it.bat_temp       = temp[TEMP_W-1:0];
    it.bat_discharged = disc;
    it.charger_active = chg;
    it.dcin_pin_level = pins[1];
    it.key_pin_level  = pins[0];
    return it;
  endfunction

  // Key event, power command or no-action item
  function automatic in_item_t ctl_item(logic [1:0] fn, logic [1:0] code, logic disc);
    in_item_t it;
    it                = '0;
    it.func           = fn;
    it.now_ms         = w_time;
    it.key_event      = code;
    it.power_cmd      = code;
    it.bat_discharged = disc;
    return it;
  endfunction

  // Mostly ticks from a drifting world, with temperatures around the limits
  function automatic in_item_t random_item();
    in_item_t it;
    int       r;
    int       k;
    int       h;
    r = $urandom_range(99);
    if (r < 3) w_time = $urandom();
    else if (r < 8) ;
    else if (r < 80) w_time += $urandom_range(1, 3000);
    else w_time += $urandom_range(3000, 80000);
    if ($urandom_range(99) < 8) w_dc = !w_dc;
    if ($urandom_range(99) < 8) w_good = !w_good;
    if ($urandom_range(99) < 3) w_bat = !w_bat;
    r = $urandom_range(99);
    if (r < 12) begin
      k = $urandom_range(3);
      h = model.hyst;
      w_temp = int'(model.lim[k]) + int'($urandom_range(0, 2 * h + 2)) - h - 1;
    end else if (r < 14) begin
      w_temp = int'($urandom_range(0, 2 ** TEMP_W - 1)) - 2 ** (TEMP_W - 1);
    end else begin
      w_temp += int'($urandom_range(0, 3000)) - 1500;
      if (w_temp < -100000) w_temp = -100000;
      if (w_temp > 150000) w_temp = 150000;
    end
    it = tick_item(w_time, w_dc, w_good, w_bat, w_temp, $urandom_range(99) < 15,
                   $urandom_range(99) < 70,
                   ($urandom_range(1) == 0) ? 2'b00 : 2'($urandom_range(3)));
    it.key_event = 2'($urandom_range(3));
    it.power_cmd = 2'($urandom_range(3));
    r = $urandom_range(99);
    if (r >= 97) it = {$urandom(), $urandom()};
    else if (r >= 88) it.func = FN_CMD;
    else if (r >= 78) it.func = FN_KEY;
    return it;
  endfunction

  // Rapid supply flapping: quick charge failures drive the counters to saturation
  function automatic in_item_t flap_item(int i);
    logic dc;
    logic good;
    w_time += $urandom_range(1, 2000);
    if (i % 2 == 0) begin
      dc   = 1'b1;
      good = 1'b1;
    end else begin
      dc   = ($urandom_range(9) < 2);
      good = 1'b0;
    end
    return tick_item(w_time, dc, good, 1'b1, 20000 + int'($urandom_range(100)), 1'b0,
                     1'($urandom_range(1)), 2'b00);
  endfunction

  // Result side: sample before the edge, check after it, then choose ready
  initial begin
    int        taken;
    int        hold_left;
    logic      take;
    res_item_t got;
    taken = 0;
    hold_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      take = out_bus.valid && out_bus.ready;
      got.status_flags        = out_bus.status_flags;
      got.charger_enable      = out_bus.charger_enable;
      got.supply_enable       = out_bus.supply_enable;
      got.irq_raise           = out_bus.irq_raise;
      got.charge_fail_reason  = out_bus.charge_fail_reason;
      got.power_fail_reason   = out_bus.power_fail_reason;
      got.ignore_dcin_voltage = out_bus.ignore_dcin_voltage;
      got.next_poll_ms        = out_bus.next_poll_ms;
      got.sleep_allowed       = out_bus.sleep_allowed;
      @(posedge clk);
      if (take === 1'b1) begin
        model.check_status(got);
        taken++;
        // Long hold-off while the sender keeps offering, to back the core up
        if (taken == 400) hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= steady ? 1'b1 : ($urandom_range(99) >= 24);
      end
    end
  end

  // Run limit
  initial begin
    #1600000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst                   <= 1'b1;
    in_bus.valid          <= 1'b0;
    in_bus.func           <= FN_TICK;
    in_bus.now_ms         <= '0;
    in_bus.dc_detect      <= 1'b0;
    in_bus.dc_in_range    <= 1'b0;
    in_bus.bat_detect     <= 1'b0;
    in_bus.bat_temp       <= '0;
    in_bus.bat_discharged <= 1'b0;
    in_bus.charger_active <= 1'b0;
    in_bus.key_event      <= KEY_PRESS;
    in_bus.power_cmd      <= CMD_ON;
    in_bus.dcin_pin_level <= 1'b0;
    in_bus.key_pin_level  <= 1'b0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.index         <= REG_TEMP_MIN_DIS;
    cfg_bus.data          <= '0;
    steady = 1'b0;
    w_time = '0;
    w_dc   = 1'b1;
    w_good = 1'b1;
    w_bat  = 1'b1;
    w_temp = 25000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    program_regs(RST_TEMP_MIN_DIS, RST_TEMP_MAX_DIS, RST_TEMP_MIN_CHG, RST_TEMP_MAX_CHG,
                 RST_TEMP_HYST, RST_RETRY_TEMP, RST_RETRY_LOST, RST_RETRY_BAD);

    // Directed: charge failure at time zero reads as never failed
    send_item(tick_item(32'd0, 1'b1, 1'b1, 1'b1, 25000, 1'b0, 1'b1, 2'b00));
    send_item(tick_item(32'd0, 1'b0, 1'b0, 1'b1, 25000, 1'b0, 1'b1, 2'b00));
    send_item(tick_item(32'd1, 1'b1, 1'b1, 1'b1, 25000, 1'b0, 1'b1, 2'b00));
    // Charge temperature limits with hysteresis and the temperature hold-off
    send_item(tick_item(32'd100, 1'b1, 1'b1, 1'b1, 0, 1'b0, 1'b1, 2'b00));
    send_item(tick_item(32'd200, 1'b1, 1'b1, 1'b1, 1500, 1'b0, 1'b0, 2'b00));
    send_item(tick_item(32'd300, 1'b1, 1'b1, 1'b1, 2001, 1'b0, 1'b0, 2'b00));
    send_item(tick_item(32'd70000, 1'b1, 1'b1, 1'b1, 45000, 1'b0, 1'b1, 2'b00));
    // Discharge limits, power drop without supply, sleep grant
    send_item(tick_item(32'd70100, 1'b1, 1'b1, 1'b1, 60000, 1'b0, 1'b0, 2'b00));
    send_item(tick_item(32'd70200, 1'b0, 1'b0, 1'b1, 60000, 1'b0, 1'b0, 2'b00));
    send_item(tick_item(32'd70300, 1'b0, 1'b0, 1'b1, -20000, 1'b1, 1'b0, 2'b01));
    send_item(tick_item(32'd70400, 1'b0, 1'b0, 1'b1, -100000, 1'b0, 1'b0, 2'b10));
    // Key events and power commands
    w_time = 32'd70500;
    send_item(ctl_item(FN_KEY, KEY_PRESS, 1'b0));
    send_item(ctl_item(FN_KEY, KEY_LONG_PRESS, 1'b0));
    send_item(ctl_item(FN_KEY, KEY_RELEASE, 1'b0));
    send_item(ctl_item(FN_KEY, KEY_LONG_RELEASE, 1'b0));
    send_item(ctl_item(FN_CMD, CMD_ON, 1'b1));
    send_item(tick_item(32'd71000, 1'b1, 1'b1, 1'b1, 25000, 1'b0, 1'b1, 2'b00));
    send_item(ctl_item(FN_CMD, CMD_SHUTDOWN, 1'b0));
    send_item(ctl_item(FN_CMD, CMD_ON, 1'b0));
    send_item(ctl_item(FN_CMD, CMD_ON, 1'b0));
    send_item(ctl_item(FN_CMD, CMD_REBOOT, 1'b0));
    send_item(ctl_item(FN_CMD, CMD_IGNORED, 1'b1));
    send_item(ctl_item(FN_NONE, CMD_IGNORED, 1'b1));
    // Time wrap, no battery, field extremes
    send_item(tick_item(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 150000, 1'b1, 1'b1, 2'b11));
    send_item(tick_item(32'd5, 1'b1, 1'b1, 1'b1, -100000, 1'b0, 1'b1, 2'b00));

    // Random traffic at reset settings
    w_time = 32'd100000;
    repeat (150) send_item(random_item());
    drain(4);

    // Wide limits, no margin, no hold-off: flapping supply with a steady stretch
    program_regs(-100000, 150000, -100000, 150000, 0, 32'd0, 32'd0, 32'd0);
    for (int i = 0; i < 520; i++) begin
      steady = (i >= 150 && i < 450);
      send_item(flap_item(i));
    end
    steady = 1'b0;
    drain(4);

    // Crossed extreme limits, widest margin, longest hold-offs
    program_regs(150000, -100000, 150000, -100000, 20000,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (150) send_item(random_item());
    drain(4);

    // Random settings within range
    program_regs(int'($urandom_range(0, 250000)) - 100000,
                 int'($urandom_range(0, 250000)) - 100000,
                 int'($urandom_range(0, 250000)) - 100000,
                 int'($urandom_range(0, 250000)) - 100000,
                 int'($urandom_range(0, 20000)),
                 $urandom_range(0, 100000), $urandom_range(0, 100000),
                 $urandom_range(0, 100000));
    repeat (150) send_item(random_item());
    drain(4);

    // Narrow charge window, short hold-offs
    program_regs(-5000, 40000, 10000, 30000, 500, 32'd1000, 32'd2000, 32'd3000);
    w_temp = 20000;
    repeat (150) send_item(random_item());
    drain(10);

    if (model.mismatches == 0 && model.expected_status.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
